// ===== src/s2lab_pkg.sv =====
package s2lab_pkg;

	// Output fixed point
	localparam int OUT_FRAC_BITS = 8;
	localparam int RND_SHIFT     = 20 - OUT_FRAC_BITS;
	localparam int L_MAX_RAW     = 100 << OUT_FRAC_BITS;
	localparam int L_MAX         = (L_MAX_RAW > 32767) ? 32767 : L_MAX_RAW;

	// Pipeline layout
	localparam int ROOT_BITS = 21;
	localparam int S_LIN     = 1;
	localparam int S_MAT     = 2;
	localparam int S_PP      = 3;
	localparam int S_NORM    = 4;
	localparam int S_ROOT    = 5;
	localparam int S_FVAL    = S_ROOT + ROOT_BITS;
	localparam int S_OUT     = S_FVAL + 1;
	localparam int STAGES    = S_OUT;

	// sRGB to XYZ matrix, scaled by 10000
	localparam int unsigned MAT [3][3] = '{
		'{4124, 3576, 1805},
		'{2126, 7152,  722},
		'{ 193, 1192, 9505}
	};

	// White-point normalization: (sum * NUM_MUL + NUM_ADD) / NUM_DIV
	localparam longint unsigned NUM_MUL [3] = '{20, 1, 20};
	localparam longint unsigned NUM_ADD [3] = '{95047, 5000, 108883};
	localparam longint unsigned NUM_DIV [3] = '{190094, 10000, 217766};
	localparam int              RECIP_SHIFT = 52;
	localparam longint unsigned RECIP [3] = '{
		((64'd1 << 52) + 64'd190094 - 64'd1) / 64'd190094,
		((64'd1 << 52) + 64'd10000 - 64'd1) / 64'd10000,
		((64'd1 << 52) + 64'd217766 - 64'd1) / 64'd217766
	};

	// Linear branch of f(t), split as slope*t + base + (rem*t + rnd) / 116000
	localparam int unsigned LINF_T_MAX = 580;
	localparam int unsigned LINF_SLOPE = 124;
	localparam int unsigned LINF_BASE  = 144631;
	localparam int unsigned LINF_REM   = 68672;
	localparam int unsigned LINF_RND   = 78000;
	localparam int unsigned LINF_RECIP = 151656777;
	localparam int          LINF_SHIFT = 44;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic        [14:0] lightness;
		logic signed [15:0] green_red_axis;
		logic signed [15:0] blue_yellow_axis;
	} lab_t;

	typedef logic [16:0] lin_table_t [256];

	// Gamma decode of every 8-bit code to linear Q16, evaluated at elaboration
	function automatic lin_table_t build_lin_table();
		lin_table_t      tab;
		longint unsigned c, x, s, lo, hi, mid, p, y;
		for (int i = 0; i < 256; i++) begin
			c = longint'(i);
			if (c * 100000 <= 1031475) begin
				tab[i] = 17'((c * 655360 + 16473) / 32946);
			end else begin
				x = (((1000 * c + 14025) << 30) + 134512) / 269025;
				s = (x * x + (64'd1 << 29)) >> 30;
				lo = 0;
				hi = 64'd1 << 30;
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					p = mid;
					for (int n = 0; n < 4; n++)
						p = (p * mid) >> 30;
					if (p <= s)
						lo = mid;
					else
						hi = mid - 1;
				end
				y = (s * lo) >> 30;
				tab[i] = 17'((y + (64'd1 << 13)) >> 14);
			end
		end
		return tab;
	endfunction

	localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

// ===== src/srgb_to_cielab_core.sv =====
// sRGB to CIELAB (D65) converter, one pixel per clock while lab_ready is high.
// Request channel: pixel (red, green, blue, 8 bits each) with pixel_valid and
// pixel_ready. Result channel: lab (L*, a*, b* in 1/256 units) with lab_valid
// and lab_ready. A request is taken on a clock edge where valid and ready are
// both high.
// Throughput is one pixel per cycle when the receiver keeps lab_ready high.
// The depth is set by the cube root, which resolves one result bit per stage
// over 21 stages, behind gamma lookup, matrix and the two white-point
// scaling stages, and followed by branch select and output scaling. The
// linear f(t) branch is computed alongside the first two cube root stages.
// Each stage holds its own valid bit. When lab_ready is low the last stage
// holds, and stages behind it keep advancing into empty slots, so
// pixel_ready drops only once every stage is occupied.
// Reset (arst_n low) empties the pipeline; in-flight pixels are dropped and
// no result is shown until new requests arrive.
module srgb_to_cielab_core import s2lab_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pixel_valid,
	output logic   pixel_ready,
	input  pixel_t pixel,
	output logic   lab_valid,
	input  logic   lab_ready,
	output lab_t   lab
);

	logic [STAGES:1] vld_q;
	logic [STAGES:1] adv;

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		adv[STAGES] = !vld_q[STAGES] || lab_ready;
		for (int k = STAGES - 1; k >= 1; k--)
			adv[k] = !vld_q[k] || adv[k + 1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1])
				vld_q[1] <= pixel_valid;
			for (int k = 2; k <= STAGES; k++)
				if (adv[k])
					vld_q[k] <= vld_q[k - 1];
		end
	end

	assign pixel_ready = adv[1];
	assign lab_valid   = vld_q[STAGES];

	// Stage 1: gamma decode lookup
	logic [16:0] lin_s1 [3];

	always_ff @(posedge clk) begin
		if (adv[S_LIN]) begin
			lin_s1[0] <= LIN_TABLE[pixel.red];
			lin_s1[1] <= LIN_TABLE[pixel.green];
			lin_s1[2] <= LIN_TABLE[pixel.blue];
		end
	end

	// Stage 2: matrix to unnormalized XYZ
	logic [29:0] sum_s2 [3];
	logic [29:0] sum_d  [3];

	always_comb begin
		for (int r = 0; r < 3; r++)
			sum_d[r] = 30'(MAT[r][0]) * {13'b0, lin_s1[0]}
				+ 30'(MAT[r][1]) * {13'b0, lin_s1[1]}
				+ 30'(MAT[r][2]) * {13'b0, lin_s1[2]};
	end

	always_ff @(posedge clk) begin
		if (adv[S_MAT])
			sum_s2 <= sum_d;
	end

	// Stage 3: partial products of the reciprocal multiply
	logic [36:0] pp_s3 [3][4];
	logic [33:0] num_d [3];
	logic [19:0] rlo_d [3];
	logic [19:0] rhi_d [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			num_d[r] = 34'(NUM_MUL[r]) * {4'b0, sum_s2[r]} + 34'(NUM_ADD[r]);
			rlo_d[r] = RECIP[r][19:0];
			rhi_d[r] = RECIP[r][39:20];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[S_PP]) begin
			for (int r = 0; r < 3; r++) begin
				pp_s3[r][0] <= {20'b0, num_d[r][16:0]} * {17'b0, rlo_d[r]};
				pp_s3[r][1] <= {20'b0, num_d[r][16:0]} * {17'b0, rhi_d[r]};
				pp_s3[r][2] <= {20'b0, num_d[r][33:17]} * {17'b0, rlo_d[r]};
				pp_s3[r][3] <= {20'b0, num_d[r][33:17]} * {17'b0, rhi_d[r]};
			end
		end
	end

	// Stage 4: sum partial products, take quotient, limit to 17 bits
	logic [16:0] t_s4   [3];
	logic [73:0] prod_d [3];
	logic [21:0] quo_d  [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			prod_d[r] = {37'b0, pp_s3[r][0]}
				+ ({37'b0, pp_s3[r][1]} << 20)
				+ ({37'b0, pp_s3[r][2]} << 17)
				+ ({37'b0, pp_s3[r][3]} << 37);
			quo_d[r] = prod_d[r][73:RECIP_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[S_NORM]) begin
			for (int r = 0; r < 3; r++)
				t_s4[r] <= (quo_d[r] > 22'h1FFFF) ? 17'h1FFFF : quo_d[r][16:0];
		end
	end

	// Cube root stages: one result bit each; the linear branch rides along
	logic [20:0] rt_y_s   [ROOT_BITS][3];
	logic [41:0] rt_y2_s  [ROOT_BITS][3];
	logic [62:0] rt_y3_s  [ROOT_BITS][3];
	logic [16:0] rt_t_s   [ROOT_BITS][3];
	logic        rt_sml_s [ROOT_BITS][3];
	logic [53:0] rt_aux_s [ROOT_BITS][3];

	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
		localparam int K   = ROOT_BITS - 1 - j;
		localparam int STG = S_ROOT + j;

		logic [20:0] y_in   [3];
		logic [41:0] y2_in  [3];
		logic [62:0] y3_in  [3];
		logic [16:0] t_in   [3];
		logic        sml_in [3];
		logic [53:0] aux_in [3];
		logic [63:0] c3     [3];
		logic [63:0] c2     [3];
		logic [63:0] vcmp   [3];

		if (j == 0) begin : g_first
			always_comb begin
				for (int r = 0; r < 3; r++) begin
					y_in[r]   = '0;
					y2_in[r]  = '0;
					y3_in[r]  = '0;
					t_in[r]   = t_s4[r];
					sml_in[r] = ({15'b0, t_s4[r]} <= 32'(LINF_T_MAX));
					aux_in[r] = 54'(26'(LINF_REM) * {9'b0, t_s4[r]} + 26'(LINF_RND))
						* 54'(LINF_RECIP);
				end
			end
		end else if (j == 1) begin : g_lin
			always_comb begin
				for (int r = 0; r < 3; r++) begin
					y_in[r]   = rt_y_s[j - 1][r];
					y2_in[r]  = rt_y2_s[j - 1][r];
					y3_in[r]  = rt_y3_s[j - 1][r];
					t_in[r]   = rt_t_s[j - 1][r];
					sml_in[r] = rt_sml_s[j - 1][r];
					aux_in[r] = 54'(LINF_SLOPE) * {37'b0, rt_t_s[j - 1][r]}
						+ 54'(LINF_BASE)
						+ {44'b0, rt_aux_s[j - 1][r][53:LINF_SHIFT]};
				end
			end
		end else begin : g_mid
			always_comb begin
				for (int r = 0; r < 3; r++) begin
					y_in[r]   = rt_y_s[j - 1][r];
					y2_in[r]  = rt_y2_s[j - 1][r];
					y3_in[r]  = rt_y3_s[j - 1][r];
					t_in[r]   = rt_t_s[j - 1][r];
					sml_in[r] = rt_sml_s[j - 1][r];
					aux_in[r] = rt_aux_s[j - 1][r];
				end
			end
		end

		// Trial (y + 2^K)^3 and (y + 2^K)^2 by shifts and adds
		always_comb begin
			for (int r = 0; r < 3; r++) begin
				c3[r] = {1'b0, y3_in[r]}
					+ (({22'b0, y2_in[r]} * 64'd3) << K)
					+ (({43'b0, y_in[r]} * 64'd3) << (2 * K))
					+ (64'd1 << (3 * K));
				c2[r] = {22'b0, y2_in[r]}
					+ ({43'b0, y_in[r]} << (K + 1))
					+ (64'd1 << (2 * K));
				vcmp[r] = {3'b0, t_in[r], 44'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (adv[STG]) begin
				for (int r = 0; r < 3; r++) begin
					if (c3[r] <= vcmp[r]) begin
						rt_y_s[j][r]  <= y_in[r] | (21'd1 << K);
						rt_y2_s[j][r] <= c2[r][41:0];
						rt_y3_s[j][r] <= c3[r][62:0];
					end else begin
						rt_y_s[j][r]  <= y_in[r];
						rt_y2_s[j][r] <= y2_in[r];
						rt_y3_s[j][r] <= y3_in[r];
					end
					rt_t_s[j][r]   <= t_in[r];
					rt_sml_s[j][r] <= sml_in[r];
					rt_aux_s[j][r] <= aux_in[r];
				end
			end
		end
	end

	// Select f(t) branch
	logic [20:0] f_s26 [3];

	always_ff @(posedge clk) begin
		if (adv[S_FVAL]) begin
			for (int r = 0; r < 3; r++)
				f_s26[r] <= rt_sml_s[ROOT_BITS - 1][r]
					? rt_aux_s[ROOT_BITS - 1][r][20:0]
					: rt_y_s[ROOT_BITS - 1][r];
		end
	end

	// Output scaling, rounding and clipping
	logic signed [31:0] fx_w, fy_w, fz_w;
	logic signed [31:0] lv, av, bv;
	logic signed [31:0] lq, aq, bq;
	lab_t               lab_d;
	lab_t               lab_s27;

	localparam logic signed [31:0] RND_HALF = 32'sd1 <<< (RND_SHIFT - 1);
	localparam logic signed [31:0] L_OFFSET = 32'sd16 <<< 20;

	always_comb begin
		fx_w = signed'({11'b0, f_s26[0]});
		fy_w = signed'({11'b0, f_s26[1]});
		fz_w = signed'({11'b0, f_s26[2]});
		lv = 32'sd116 * fy_w - L_OFFSET + RND_HALF;
		av = 32'sd500 * (fx_w - fy_w) + RND_HALF;
		bv = 32'sd200 * (fy_w - fz_w) + RND_HALF;
		lq = lv >>> RND_SHIFT;
		aq = av >>> RND_SHIFT;
		bq = bv >>> RND_SHIFT;

		if (lq < 0)
			lab_d.lightness = '0;
		else if (lq > 32'(L_MAX))
			lab_d.lightness = 15'(L_MAX);
		else
			lab_d.lightness = lq[14:0];

		if (aq < -32'sd32768)
			lab_d.green_red_axis = 16'sh8000;
		else if (aq > 32'sd32767)
			lab_d.green_red_axis = 16'sh7FFF;
		else
			lab_d.green_red_axis = aq[15:0];

		if (bq < -32'sd32768)
			lab_d.blue_yellow_axis = 16'sh8000;
		else if (bq > 32'sd32767)
			lab_d.blue_yellow_axis = 16'sh7FFF;
		else
			lab_d.blue_yellow_axis = bq[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv[S_OUT])
			lab_s27 <= lab_d;
	end

	assign lab = lab_s27;

endmodule
